/* rtl/kpsd_pkg.sv */
package kpsd_pkg;

  localparam int ROW_W = 4;
  localparam int COL_W = 5;
  localparam int KEY_W = 5;
  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [TICK_W-1:0] CONFIRM_RST = 16'd20;
  localparam logic [TICK_W-1:0] RELEASE_RST = 16'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_RELEASE = 2'd2
  } kpsd_phase_t;

  // push request from the debounce control into the key fifo
  typedef struct packed {
    logic             wr;
    logic [KEY_W-1:0] key;
    logic             drop;
  } kpsd_push_t;

  // a programmed tick count of zero behaves as one
  function automatic logic [TICK_W-1:0] nz_ticks(input logic [TICK_W-1:0] t);
    nz_ticks = (t == '0) ? TICK_W'(1) : t;
  endfunction

endpackage

/* rtl/keypad_scan_debounce_fifo_unit.sv */
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_req_type, in_row_levels, in_col_levels
// out      output     out_valid / out_stall out_popped_key, out_key_pushed,
//                                          out_overflow, out_queue_count
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low; a request is latched
// in the input register, then decoded and applied to the debounce state and key
// fifo on its way into the result register, where out_valid rises.
// reset: phase idle, fifo empty, confirm 20 ticks, release poll 50 ticks.
// out_stall holds the result register and reaches in_stall in the same cycle
// only when the input register is also occupied.
module keypad_scan_debounce_fifo_unit #(
  parameter int ROWS       = 4,
  parameter int COLS       = 5,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [kpsd_pkg::ROW_W-1:0]       in_row_levels,
  input  logic [kpsd_pkg::COL_W-1:0]       in_col_levels,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kpsd_pkg::KEY_W-1:0]       out_popped_key,
  output logic                             out_key_pushed,
  output logic                             out_overflow,
  output logic [kpsd_pkg::KEY_W-1:0]       out_queue_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kpsd_pkg::TICK_W-1:0]      cfg_data
);
  import kpsd_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic              s1_valid_r;
  logic              s1_req_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic              advance;
  logic              go;
  logic [TICK_W-1:0] confirm_r;
  logic [TICK_W-1:0] release_r;
  logic [KEY_W-1:0]  key;
  kpsd_push_t        push;
  logic [KEY_W-1:0]  popped_key;
  logic              fifo_full;
  logic [CNT_W-1:0]  fifo_cnt;
  logic [CNT_W-1:0]  fifo_cnt_nxt;
  logic              out_valid_r;
  logic [KEY_W-1:0]  popped_r;
  logic              pushed_r;
  logic              overflow_r;
  logic [KEY_W-1:0]  qcount_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_r <= CONFIRM_RST;
      release_r <= RELEASE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CONFIRM: confirm_r <= cfg_data;
        CFG_RELEASE: release_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign go       = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req_type;
      s1_row_r <= in_row_levels;
      s1_col_r <= in_col_levels;
    end
  end

  kpsd_decode #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_decode (
    .row_levels (s1_row_r),
    .col_levels (s1_col_r),
    .key        (key)
  );

  kpsd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (go && !s1_req_r),
    .key           (key),
    .fifo_full     (fifo_full),
    .confirm_ticks (confirm_r),
    .release_ticks (release_r),
    .push          (push)
  );

  kpsd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (go && s1_req_r),
    .popped_key (popped_key),
    .full       (fifo_full),
    .count      (fifo_cnt),
    .count_nxt  (fifo_cnt_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      popped_r   <= popped_key;
      pushed_r   <= push.wr;
      overflow_r <= push.drop;
      qcount_r   <= KEY_W'(fifo_cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_popped_key  = popped_r;
  assign out_key_pushed  = pushed_r;
  assign out_overflow    = overflow_r;
  assign out_queue_count = qcount_r;

`ifndef SYNTHESIS
  a_push_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_key_pushed && out_overflow))
    else $error("key pushed and dropped on the same request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count beyond depth");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (go && push.wr) |=> (fifo_cnt == $past(fifo_cnt) + CNT_W'(1)))
    else $error("push did not raise the fifo count");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.drop |-> fifo_full)
    else $error("key dropped while fifo has room");
`endif

endmodule

/* rtl/kpsd_decode.sv */
module kpsd_decode #(
  parameter int ROWS = 4,
  parameter int COLS = 5
) (
  input  logic [kpsd_pkg::ROW_W-1:0] row_levels,
  input  logic [kpsd_pkg::COL_W-1:0] col_levels,
  output logic [kpsd_pkg::KEY_W-1:0] key
);
  import kpsd_pkg::*;

  localparam int RI_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CI_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SUM_W = $clog2(ROWS * COLS + 1);

  logic [ROWS-1:0] rv;
  logic [COLS-1:0] cv;
  logic            row_hit;
  logic            col_hit;
  logic [RI_W-1:0] row_idx;
  logic [CI_W-1:0] col_idx;
  logic [SUM_W-1:0] raw;

  // lines beyond the sampled fields read as low
  genvar gi;
  generate
    for (gi = 0; gi < ROWS; gi++) begin : g_row
      if (gi < ROW_W) begin : g_in
        assign rv[gi] = row_levels[gi];
      end else begin : g_lo
        assign rv[gi] = 1'b0;
      end
    end
    for (gi = 0; gi < COLS; gi++) begin : g_col
      if (gi < COL_W) begin : g_in
        assign cv[gi] = col_levels[gi];
      end else begin : g_lo
        assign cv[gi] = 1'b0;
      end
    end
  endgenerate

  // lowest low line wins
  always_comb begin
    row_hit = 1'b0;
    row_idx = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!rv[i]) begin
        row_hit = 1'b1;
        row_idx = RI_W'(i);
      end
    end
  end

  always_comb begin
    col_hit = 1'b0;
    col_idx = '0;
    for (int j = COLS - 1; j >= 0; j--) begin
      if (!cv[j]) begin
        col_hit = 1'b1;
        col_idx = CI_W'(j);
      end
    end
  end

  assign raw = SUM_W'(row_idx) * SUM_W'(COLS) + SUM_W'(col_idx) + SUM_W'(1);

  // all rows low counts as no key
  assign key = ((rv != '0) && row_hit && col_hit) ? KEY_W'(raw) : '0;

endmodule

/* rtl/kpsd_ctrl.sv */
module kpsd_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick,
  input  logic [kpsd_pkg::KEY_W-1:0]    key,
  input  logic                          fifo_full,
  input  logic [kpsd_pkg::TICK_W-1:0]   confirm_ticks,
  input  logic [kpsd_pkg::TICK_W-1:0]   release_ticks,
  output kpsd_pkg::kpsd_push_t          push
);
  import kpsd_pkg::*;

  kpsd_phase_t      phase_r, phase_nxt;
  logic [KEY_W-1:0] cand_r, cand_nxt;
  logic [TICK_W-1:0] cnt_r, cnt_nxt;
  logic [TICK_W-1:0] cnt_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cand_r  <= '0;
      cnt_r   <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign cnt_dec = (cnt_r != '0) ? cnt_r - TICK_W'(1) : '0;

  always_comb begin
    phase_nxt = phase_r;
    cand_nxt  = cand_r;
    cnt_nxt   = cnt_r;
    push      = '0;
    push.key  = key;
    unique case (phase_r)
      PH_CONFIRM: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          if (key == cand_r) begin
            push.wr   = ~fifo_full;
            push.drop = fifo_full;
          end
          cand_nxt = '0;
          if (key == '0) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RELEASE;
            cnt_nxt   = nz_ticks(release_ticks);
          end
        end
      end
      PH_RELEASE: begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          if (key == '0) begin
            phase_nxt = PH_IDLE;
          end else begin
            cnt_nxt = nz_ticks(release_ticks);
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (key != '0) begin
          cand_nxt  = key;
          cnt_nxt   = nz_ticks(confirm_ticks);
          phase_nxt = PH_CONFIRM;
        end
      end
    endcase
    if (!tick) begin
      push.wr   = 1'b0;
      push.drop = 1'b0;
    end
  end

endmodule

/* rtl/kpsd_fifo.sv */
module kpsd_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  kpsd_pkg::kpsd_push_t                 push,
  input  logic                                 pop,
  output logic [kpsd_pkg::KEY_W-1:0]           popped_key,
  output logic                                 full,
  output logic [$clog2(DEPTH+1)-1:0]           count,
  output logic [$clog2(DEPTH+1)-1:0]           count_nxt
);
  import kpsd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] head_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic             pop_ok;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop_ok     = pop && (count_r != '0);
  assign rd_ptr_nxt = pop_ok ? ptr_inc(rd_ptr_r) : rd_ptr_r;
  assign wr_ptr_nxt = push.wr ? ptr_inc(wr_ptr_r) : wr_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (push.wr) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.wr) begin
      mem[wr_ptr_r] <= push.key;
    end
  end

  // head prefetch, bypassing a write into the slot about to be read
  always_ff @(posedge clk) begin
    if (push.wr && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push.key;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign popped_key = pop_ok ? head_r : '0;
  assign full       = (count_r == CNT_W'(DEPTH));
  assign count      = count_r;

endmodule

/* bench/tb.sv */
module tb;
  import kpsd_pkg::*;

  localparam int ROWS       = 4;
  localparam int COLS       = 5;
  localparam int FIFO_DEPTH = 16;

  typedef struct packed {
    logic [KEY_W-1:0] popped;
    logic             pushed;
    logic             dropped;
    logic [KEY_W-1:0] count;
  } keypad_result_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_req_type   = 1'b0;
  logic [ROW_W-1:0]   in_row_levels = '0;
  logic [COL_W-1:0]   in_col_levels = '0;
  logic               out_stall     = 1'b0;
  logic               cfg_valid     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_CONFIRM;
  logic [TICK_W-1:0]  cfg_data      = '0;
  logic               in_stall;
  logic               out_valid;
  logic [KEY_W-1:0]   out_popped_key;
  logic               out_key_pushed;
  logic               out_overflow;
  logic [KEY_W-1:0]   out_queue_count;
  logic               cfg_ready;

  // shadow of the scanner state and registers
  kpsd_phase_t        scan_phase;
  logic [KEY_W-1:0]   held_key;
  logic [TICK_W-1:0]  ticks_left;
  logic [KEY_W-1:0]   key_mem [FIFO_DEPTH];
  logic [3:0]         key_rd;
  logic [3:0]         key_wr;
  logic [KEY_W-1:0]   key_cnt;
  logic [TICK_W-1:0]  confirm_len;
  logic [TICK_W-1:0]  poll_len;

  keypad_result_t     pending_results [$];
  int                 err_cnt   = 0;
  int                 sent_cnt  = 0;
  int                 idle_pct  = 0;
  int                 stall_pct = 0;
  int                 hold_len  = 0;

  keypad_scan_debounce_fifo_unit #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_row_levels   (in_row_levels),
    .in_col_levels   (in_col_levels),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_popped_key  (out_popped_key),
    .out_key_pushed  (out_key_pushed),
    .out_overflow    (out_overflow),
    .out_queue_count (out_queue_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // lowest low row and lowest low column pick the key
  function automatic logic [KEY_W-1:0] key_from_levels(logic [ROW_W-1:0] rows,
                                                       logic [COL_W-1:0] cols);
    int r;
    int c;
    r = -1;
    c = -1;
    if (rows == '0) return '0;
    for (int i = ROWS - 1; i >= 0; i--) if (!rows[i]) r = i;
    for (int j = COLS - 1; j >= 0; j--) if (!cols[j]) c = j;
    if (r < 0 || c < 0) return '0;
    return KEY_W'(r * COLS + c + 1);
  endfunction

  function automatic keypad_result_t predict_keypad(logic pop, logic [ROW_W-1:0] rows,
                                                    logic [COL_W-1:0] cols);
    keypad_result_t res;
    logic [KEY_W-1:0] k;
    res = '0;
    if (pop) begin
      if (key_cnt != 0) begin
        res.popped = key_mem[key_rd];
        key_rd = key_rd + 1'b1;
        key_cnt = key_cnt - 1'b1;
      end
    end else begin
      k = key_from_levels(rows, cols);
      case (scan_phase)
        PH_CONFIRM: begin
          if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == 0) begin
            if (k == held_key) begin
              if (key_cnt < FIFO_DEPTH) begin
                key_mem[key_wr] = k;
                key_wr = key_wr + 1'b1;
                key_cnt = key_cnt + 1'b1;
                res.pushed = 1'b1;
              end else begin
                res.dropped = 1'b1;
              end
            end
            held_key = '0;
            if (k == 0) begin
              scan_phase = PH_IDLE;
            end else begin
              scan_phase = PH_RELEASE;
              ticks_left = (poll_len == 0) ? TICK_W'(1) : poll_len;
            end
          end
        end
        PH_RELEASE: begin
          if (ticks_left != 0) ticks_left = ticks_left - 1'b1;
          if (ticks_left == 0) begin
            if (k == 0) scan_phase = PH_IDLE;
            else ticks_left = (poll_len == 0) ? TICK_W'(1) : poll_len;
          end
        end
        default: begin
          scan_phase = PH_IDLE;
          if (k != 0) begin
            held_key = k;
            ticks_left = (confirm_len == 0) ? TICK_W'(1) : confirm_len;
            scan_phase = PH_CONFIRM;
          end
        end
      endcase
    end
    res.count = key_cnt;
    return res;
  endfunction

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  // predictor update on every accepted request, result check on every accepted output
  always @(posedge clk) begin
    keypad_result_t exp_res;
    if (!rst_n) begin
      scan_phase  = PH_IDLE;
      held_key    = '0;
      ticks_left  = '0;
      key_rd      = '0;
      key_wr      = '0;
      key_cnt     = '0;
      confirm_len = CONFIRM_RST;
      poll_len    = RELEASE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CONFIRM) confirm_len = cfg_data;
        else poll_len = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none actual key %0d count %0d",
                   $time, out_popped_key, out_queue_count);
        end else begin
          exp_res = pending_results.pop_front();
          compare_field("popped_key", exp_res.popped, out_popped_key);
          compare_field("key_pushed", exp_res.pushed, out_key_pushed);
          compare_field("overflow", exp_res.dropped, out_overflow);
          compare_field("queue_count", exp_res.count, out_queue_count);
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_keypad(in_req_type, in_row_levels, in_col_levels));
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_len != 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_req(input logic pop, input logic [ROW_W-1:0] rows,
                          input logic [COL_W-1:0] cols);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= pop;
    in_row_levels <= rows;
    in_col_levels <= cols;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // bits below pos high, bit pos low, bits above random
  function automatic logic [7:0] low_at(int pos);
    logic [7:0] v;
    v = 8'($urandom);
    for (int i = 0; i < 8; i++) if (i < pos) v[i] = 1'b1;
    v[pos] = 1'b0;
    return v;
  endfunction

  // scan tick whose levels decode to key (0 = nothing pressed)
  task automatic send_scan(input int key);
    logic [7:0] rv;
    logic [7:0] cv;
    if (key == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          rv = 8'h00;
          cv = 8'($urandom);
        end
        1: begin
          rv = 8'hff;
          cv = 8'($urandom);
        end
        default: begin
          rv = low_at($urandom_range(0, ROWS - 1));
          cv = 8'hff;
        end
      endcase
    end else begin
      rv = low_at((key - 1) / COLS);
      cv = low_at((key - 1) % COLS);
    end
    send_req(1'b0, rv[ROW_W-1:0], cv[COL_W-1:0]);
  endtask

  task automatic send_pop();
    send_req(1'b1, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic quiesce();
    int wait_cycles;
    wait_cycles = 0;
    in_valid <= 1'b0;
    // let the last accepted request reach the predictor queue first
    @(posedge clk);
    while (pending_results.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tick_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // reset registers: confirm wait of 20, field extremes, pop on empty
  task automatic test_default_confirm();
    send_pop();
    send_req(1'b0, 4'h0, 5'h00);
    send_req(1'b0, 4'hf, 5'h00);
    send_req(1'b0, 4'he, 5'h1f);
    send_scan(20);
    send_pop();
    repeat (19) send_req(1'b0, ROW_W'($urandom), COL_W'($urandom));
    send_scan(0);
    send_pop();
  endtask

  // zero registers act as one; mismatch and release at the confirming read
  task automatic test_zero_ticks();
    quiesce();
    write_tick_reg(CFG_CONFIRM, 16'd0);
    write_tick_reg(CFG_RELEASE, 16'd0);
    send_scan(7);
    send_pop();
    send_scan(7);
    send_scan(7);
    send_scan(0);
    send_scan(3);
    send_scan(9);
    send_scan(0);
    send_scan(12);
    send_scan(0);
    send_scan(1);
    send_scan(1);
    send_scan(0);
    repeat (3) send_pop();
  endtask

  // long confirm and release waits, levels ignored in between
  task automatic test_max_ticks();
    idle_pct  = 0;
    stall_pct = 0;
    quiesce();
    write_tick_reg(CFG_CONFIRM, 16'd200);
    write_tick_reg(CFG_RELEASE, 16'd200);
    send_scan(14);
    repeat (199) send_req(1'b0, ROW_W'($urandom), COL_W'($urandom));
    send_scan(14);
    repeat (199) send_req(1'b0, ROW_W'($urandom), COL_W'($urandom));
    send_scan(0);
    send_pop();
  endtask

  // fill the fifo past its depth, then drain it past empty
  task automatic test_fifo_overflow();
    quiesce();
    write_tick_reg(CFG_CONFIRM, 16'd1);
    write_tick_reg(CFG_RELEASE, 16'd1);
    for (int i = 0; i < FIFO_DEPTH + 2; i++) begin
      send_scan(i % 20 + 1);
      send_scan(i % 20 + 1);
      send_scan(0);
    end
    repeat (FIFO_DEPTH + 2) send_pop();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_len  = 120;
    for (int i = 0; i < 12; i++) begin
      send_scan(i + 5);
      send_scan(i + 5);
      send_scan(0);
      send_pop();
    end
  endtask

  task automatic test_random_traffic();
    int idle_tab [4]  = '{0, 71, 0, 27};
    int stall_tab [4] = '{0, 0, 71, 27};
    int pop_tab [4]   = '{10, 20, 15, 25};
    int conf;
    int rel;
    int key;
    int start_cnt;
    for (int m = 0; m < 4; m++) begin
      idle_pct  = idle_tab[m];
      stall_pct = stall_tab[m];
      quiesce();
      conf = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      rel  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      write_tick_reg(CFG_CONFIRM, TICK_W'(conf));
      write_tick_reg(CFG_RELEASE, TICK_W'(rel));
      start_cnt = sent_cnt;
      while (sent_cnt - start_cnt < 200) begin
        case ($urandom_range(0, 99)) inside
          [0:9]: send_req(1'(($urandom)), ROW_W'($urandom), COL_W'($urandom));
          [10:22]: repeat ($urandom_range(1, 5)) send_pop();
          default: begin
            // press, hold with occasional bounce, then release
            key = $urandom_range(1, 20);
            repeat ($urandom_range(1, conf + 2 * rel + 3)) begin
              if ($urandom_range(0, 99) < 8) send_scan($urandom_range(0, 20));
              else send_scan(key);
              if ($urandom_range(0, 99) < pop_tab[m]) send_pop();
            end
            repeat ($urandom_range(1, 2 * rel + 2)) send_scan(0);
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_default_confirm();
    test_zero_ticks();
    test_max_ticks();
    test_fifo_overflow();
    test_backpressure();
    test_random_traffic();
    idle_pct  = 0;
    stall_pct = 0;
    quiesce();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_cnt++;
      $display("%0t: missing results, expected %0d more actual 0", $time,
               pending_results.size());
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kpsd_pkg.sv
rtl/kpsd_decode.sv
rtl/kpsd_ctrl.sv
rtl/kpsd_fifo.sv
rtl/keypad_scan_debounce_fifo_unit.sv
bench/tb.sv
